// File: hw/rtl/hsot_pkg.sv
// shared types and constants for the hash slot owner table
// no dependencies; imported by hsot_cover_count, hash_slot_owner_table and the testbench
`timescale 1ns / 1ps

package hsot_pkg;

    // fixed field widths of the stream beats
    localparam int SLOT_W    = 16;
    localparam int OWNER_W   = 8;
    localparam int CHANGED_W = 15;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 32;

    typedef enum logic [1:0] {
        CMD_LOOKUP   = 2'd0,
        CMD_ASSIGN   = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_REASSOC  = 2'd3
    } cmd_t;

    // one entry write as seen by the coverage counter
    typedef struct packed {
        logic we;
        logic old_valid;
        logic new_valid;
    } cnt_upd_t;

endpackage

// File: hw/rtl/hsot_cover_count.sv
// count of table entries holding a valid owner, with full-coverage flag
// depends on hsot_pkg
`timescale 1ns / 1ps

module hsot_cover_count #(
    parameter int SLOT_COUNT = 16384
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hsot_pkg::cnt_upd_t upd,
    output logic              covered_next
);
    import hsot_pkg::*;

    localparam int CW = $clog2(SLOT_COUNT + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (upd.we && !upd.old_valid && upd.new_valid)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (upd.we && upd.old_valid && !upd.new_valid)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    // flag reflects the write that lands at this edge
    assign covered_next = (count_next == CW'(SLOT_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/hash_slot_owner_table.sv
// hash slot owner table: slot to owner map with lookup, assign, remove, reassociate
// depends on hsot_pkg and hsot_cover_count
`timescale 1ns / 1ps
// lookup, assign and remove read the entry as the beat is accepted; the result is loaded
//   once the output register is free, and no new beat is taken until then
// reassociate walks the whole table through the single memory read port
// results sit in an output register, so a waiting result does not block the next input
// reset: a clearing pass writes the invalid marker to every entry, one per cycle,
//   with s_tready low throughout; the coverage count resets to zero at once

module hash_slot_owner_table #(
    parameter int SLOT_COUNT = 16384,
    parameter int OWNER_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // cmd[1:0], slot[17:2], new_owner[25:18], old_owner[33:26], zero pad
    input  logic [hsot_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // owner[7:0], status[8], changed_count[23:9], all_covered[24], zero pad
    output logic [hsot_pkg::OUT_W-1:0] m_tdata
);
    import hsot_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [OWNER_BITS-1:0] INVALID = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_TAIL,
        ST_RESULT
    } state_t;

    // table storage, no reset: cleared by the sweep after reset
    logic [OWNER_BITS-1:0] mem [SLOT_COUNT];

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [OWNER_BITS-1:0] to_reg;
    logic [OWNER_BITS-1:0] from_reg;
    logic [CW-1:0]         walk_addr_reg;
    logic                  pend_reg;
    logic [AW-1:0]         pend_addr_reg;
    logic [CW-1:0]         changed_reg;
    logic [OWNER_BITS-1:0] rd_data_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    // input beat fields
    cmd_t                  in_cmd;
    logic [SLOT_W-1:0]     in_slot;
    logic [OWNER_W-1:0]    in_new;
    logic [OWNER_W-1:0]    in_old;

    // memory port controls
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [OWNER_BITS-1:0] mem_wdata;

    logic                  accept;
    logic                  out_free;
    logic                  emit;
    logic                  in_range;
    logic                  hit;
    logic                  walk_last;
    logic                  covered_next;
    cnt_upd_t              upd;

    assign in_cmd  = cmd_t'(s_tdata[1:0]);
    assign in_slot = s_tdata[17:2];
    assign in_new  = s_tdata[25:18];
    assign in_old  = s_tdata[33:26];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    // a result beat is loaded into the output register this cycle
    assign emit     = out_free && ((state_reg == ST_EXEC) || (state_reg == ST_RESULT));
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_range  = ({1'b0, slot_reg} < (SLOT_W + 1)'(SLOT_COUNT));
    // entry read last cycle matches the reassociate source
    assign hit       = pend_reg && (rd_data_reg == from_reg);
    assign walk_last = (walk_addr_reg == CW'(SLOT_COUNT - 1));

    // memory port steering
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = in_slot[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = to_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = walk_addr_reg[AW-1:0];
                mem_wdata = INVALID;
            end
            ST_IDLE:
            begin
                rd_en = s_tvalid;
            end
            ST_EXEC:
            begin
                mem_waddr = slot_reg[AW-1:0];
                mem_wdata = (cmd_reg == CMD_ASSIGN) ? to_reg : INVALID;
                mem_we    = out_free && in_range && (cmd_reg != CMD_LOOKUP);
            end
            ST_WALK:
            begin
                rd_en   = 1'b1;
                rd_addr = walk_addr_reg[AW-1:0];
                mem_we  = hit;
            end
            ST_TAIL:
            begin
                mem_we = hit;
            end
            ST_RESULT:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // rd_data_reg holds the entry being overwritten on every write outside the clearing pass
    assign upd.we        = mem_we && (state_reg != ST_CLEAR);
    assign upd.old_valid = (rd_data_reg != INVALID);
    assign upd.new_valid = (mem_wdata != INVALID);

    hsot_cover_count #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_count (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (upd),
        .covered_next (covered_next)
    );

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cmd_reg       <= CMD_LOOKUP;
            slot_reg      <= '0;
            to_reg        <= '0;
            from_reg      <= '0;
            walk_addr_reg <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            changed_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end
        else
        begin
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (walk_last)
                    begin
                        walk_addr_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        walk_addr_reg <= CW'(walk_addr_reg + 1'b1);
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg  <= in_cmd;
                        slot_reg <= in_slot;
                        to_reg   <= OWNER_BITS'(in_new);
                        from_reg <= OWNER_BITS'(in_old);
                        if (in_cmd == CMD_REASSOC)
                        begin
                            walk_addr_reg <= '0;
                            pend_reg      <= 1'b0;
                            changed_reg   <= '0;
                            state_reg     <= ST_WALK;
                        end
                        else
                        begin
                            state_reg <= ST_EXEC;
                        end
                    end
                end
                ST_EXEC:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg <= OUT_W'({covered_next, {CHANGED_W{1'b0}}, !in_range,
                                              (cmd_reg == CMD_LOOKUP && in_range)
                                              ? OWNER_W'(rd_data_reg) : OWNER_W'(INVALID)});
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_WALK:
                begin
                    if (hit)
                    begin
                        changed_reg <= CW'(changed_reg + 1'b1);
                    end
                    pend_reg      <= 1'b1;
                    pend_addr_reg <= walk_addr_reg[AW-1:0];
                    walk_addr_reg <= CW'(walk_addr_reg + 1'b1);
                    if (walk_last)
                    begin
                        state_reg <= ST_TAIL;
                    end
                end
                ST_TAIL:
                begin
                    // last entry read by the walk
                    if (hit)
                    begin
                        changed_reg <= CW'(changed_reg + 1'b1);
                    end
                    pend_reg  <= 1'b0;
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg <= OUT_W'({covered_next, CHANGED_W'(changed_reg), 1'b0,
                                              OWNER_W'(INVALID)});
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // the table is never written while waiting for a beat
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("table write while idle");

    // a reassociate cannot count more rewrites than entries it has read
    a_changed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (changed_reg <= walk_addr_reg))
        else $error("changed count ahead of walk position");

    // no result can appear before the clearing sweep is over
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !m_tvalid_reg)
        else $error("result during clearing sweep");

    // an accepted beat always drops ready, since the block leaves the idle state
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("ready right after accept");

endmodule

// File: test/hash_slot_owner_table_test.sv
// testbench for hash_slot_owner_table: directed table then random command stream
// depends on hsot_pkg and hash_slot_owner_table; keeps its own copy of the slot map
`timescale 1ns / 1ps

module hash_slot_owner_table_test;
    import hsot_pkg::*;

    localparam int SLOTS = 16384;
    localparam logic [OWNER_W-1:0] NO_OWNER = 8'hFF;
    localparam int RANDOM_ITEMS = 1730;
    // a reassociate or the clearing pass after reset accepts nothing while it walks the whole table
    localparam int IDLE_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic [OWNER_W-1:0]   owner;
        logic                 status;
        logic [CHANGED_W-1:0] changed;
        logic                 covered;
    } result_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [OWNER_W-1:0] to;
        logic [OWNER_W-1:0] from;
        logic               typed;
        result_t            want;
    } stim_row_t;

    localparam result_t NOT_TYPED    = '0;
    localparam result_t EMPTY_TABLE  = '{8'hFF, 1'b0, 15'd0, 1'b0};
    localparam result_t OUT_OF_RANGE = '{8'hFF, 1'b1, 15'd0, 1'b0};

    localparam int DIRECTED_ROWS = 23;

    // typed rows can be read off directly: fresh table lookups and range errors
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_LOOKUP,  16'd0,     8'h00, 8'h00, 1'b1, EMPTY_TABLE},
        '{CMD_LOOKUP,  16'd16383, 8'hFF, 8'hFF, 1'b1, EMPTY_TABLE},
        '{CMD_LOOKUP,  16'd16384, 8'h00, 8'h00, 1'b1, OUT_OF_RANGE},
        '{CMD_ASSIGN,  16'hFFFF,  8'h07, 8'h00, 1'b1, OUT_OF_RANGE},
        '{CMD_REMOVE,  16'd16384, 8'h00, 8'h00, 1'b1, OUT_OF_RANGE},
        '{CMD_ASSIGN,  16'd0,     8'h00, 8'hFF, 1'b0, NOT_TYPED},
        '{CMD_ASSIGN,  16'd16383, 8'hFE, 8'h00, 1'b0, NOT_TYPED},
        '{CMD_LOOKUP,  16'd0,     8'hFF, 8'hFF, 1'b0, NOT_TYPED},
        '{CMD_LOOKUP,  16'd16383, 8'h00, 8'h00, 1'b0, NOT_TYPED},
        // assigning the invalid marker behaves as a remove
        '{CMD_ASSIGN,  16'd5,     8'hFF, 8'h00, 1'b0, NOT_TYPED},
        '{CMD_LOOKUP,  16'd5,     8'h00, 8'h00, 1'b0, NOT_TYPED},
        '{CMD_ASSIGN,  16'd1,     8'hAA, 8'h55, 1'b0, NOT_TYPED},
        '{CMD_REMOVE,  16'd1,     8'h33, 8'hCC, 1'b0, NOT_TYPED},
        '{CMD_LOOKUP,  16'd1,     8'h00, 8'h00, 1'b0, NOT_TYPED},
        // equal source and target still counts matches; slot is ignored
        '{CMD_REASSOC, 16'hFFFF,  8'h00, 8'h00, 1'b0, NOT_TYPED},
        // unassigned slots to a valid index: full coverage
        '{CMD_REASSOC, 16'd0,     8'h55, 8'hFF, 1'b0, NOT_TYPED},
        '{CMD_LOOKUP,  16'd100,   8'h00, 8'h00, 1'b0, NOT_TYPED},
        '{CMD_ASSIGN,  16'd100,   8'hFF, 8'h00, 1'b0, NOT_TYPED},
        '{CMD_ASSIGN,  16'd100,   8'h03, 8'h00, 1'b0, NOT_TYPED},
        '{CMD_REASSOC, 16'h4000,  8'hFF, 8'h55, 1'b0, NOT_TYPED},
        '{CMD_REASSOC, 16'd0,     8'hFF, 8'hFF, 1'b0, NOT_TYPED},
        '{CMD_REMOVE,  16'd0,     8'h00, 8'h00, 1'b0, NOT_TYPED},
        '{CMD_LOOKUP,  16'h3FFF,  8'h00, 8'h00, 1'b0, NOT_TYPED}
    };

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    logic [OWNER_W-1:0] owner_map [SLOTS];
    int                 valid_entries;
    result_t            pending_results [$];
    int                 mismatches;
    int                 idle_cycles;
    bit                 no_idle;

    hash_slot_owner_table #(
        .SLOT_COUNT (SLOTS),
        .OWNER_BITS (OWNER_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // keeps the count of valid entries in step with every write
    function automatic void write_entry(int idx, logic [OWNER_W-1:0] val);
        if (owner_map[idx] != NO_OWNER && val == NO_OWNER)
            valid_entries--;
        else if (owner_map[idx] == NO_OWNER && val != NO_OWNER)
            valid_entries++;
        owner_map[idx] = val;
    endfunction

    function automatic result_t apply_command(cmd_t cmd, logic [SLOT_W-1:0] slot,
                                              logic [OWNER_W-1:0] to,
                                              logic [OWNER_W-1:0] from);
        result_t r;
        int      i;
        r = '{NO_OWNER, 1'b0, 15'd0, 1'b0};
        if (cmd == CMD_REASSOC)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                if (owner_map[i] == from)
                begin
                    write_entry(i, to);
                    r.changed++;
                end
            end
        end
        else if (slot >= SLOTS)
            r.status = 1'b1;
        else
        begin
            case (cmd)
                CMD_LOOKUP: r.owner = owner_map[slot];
                CMD_ASSIGN: write_entry(int'(slot), to);
                default:    write_entry(int'(slot), NO_OWNER);
            endcase
        end
        r.covered = (valid_entries == SLOTS);
        return r;
    endfunction

    task automatic send_item(cmd_t cmd, logic [SLOT_W-1:0] slot, logic [OWNER_W-1:0] to,
                             logic [OWNER_W-1:0] from, logic typed, result_t want);
        int      gap;
        result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, from, to, slot, cmd};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predicted = apply_command(cmd, slot, to, from);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            if (mismatches < SHOWN_MISMATCHES)
                $display("unexpected result beat: %h", got);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.owner !== want.owner || got.status !== want.status ||
                got.changed !== want.changed || got.covered !== want.covered)
            begin
                if (mismatches < SHOWN_MISMATCHES)
                    $display("mismatch: owner %h/%h status %b/%b changed %0d/%0d covered %b/%b",
                             want.owner, got.owner, want.status, got.status,
                             want.changed, got.changed, want.covered, got.covered);
                mismatches++;
            end
        end
    endtask

    // result side: random stalls between beats
    initial
    begin
        int stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            check_result(result_t'{m_tdata[7:0], m_tdata[8], m_tdata[23:9], m_tdata[24]});
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int                 k;
        int                 pick;
        cmd_t               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [OWNER_W-1:0] to;
        logic [OWNER_W-1:0] from;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        no_idle     = 1'b0;
        for (k = 0; k < SLOTS; k++)
            owner_map[k] = NO_OWNER;
        valid_entries = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++)
            send_item(DIRECTED[k].cmd, DIRECTED[k].slot, DIRECTED[k].to,
                      DIRECTED[k].from, DIRECTED[k].typed, DIRECTED[k].want);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            // now and then a stretch with no gaps on either side
            if (k % 64 == 0)
                no_idle = ($urandom_range(0, 3) == 0);

            // reassociate is rare since it walks the whole table
            if ($urandom_range(0, 99) == 0)
                cmd = CMD_REASSOC;
            else
            begin
                pick = $urandom_range(0, 9);
                cmd  = (pick < 4) ? CMD_LOOKUP : (pick < 7) ? CMD_ASSIGN : CMD_REMOVE;
            end

            // mostly a small working set so lookups hit written slots
            pick = $urandom_range(0, 9);
            if (pick < 6)
                slot = SLOT_W'($urandom_range(0, 63));
            else if (pick < 8)
                slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            else if (pick == 8)
                slot = SLOT_W'(SLOTS - 1 - $urandom_range(0, 63));
            else
                slot = SLOT_W'($urandom_range(SLOTS, 65535));

            pick = $urandom_range(0, 9);
            if (pick < 6)
                to = OWNER_W'($urandom_range(0, 7));
            else if (pick < 8)
                to = NO_OWNER;
            else
                to = OWNER_W'($urandom_range(0, 255));

            if (cmd == CMD_REASSOC)
            begin
                pick = $urandom_range(0, 2);
                from = (pick == 0) ? NO_OWNER : 8'($urandom_range(0, 7));
            end
            else
                from = OWNER_W'($urandom_range(0, 255));

            send_item(cmd, slot, to, from, 1'b0, NOT_TYPED);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/hsot_pkg.sv
hw/rtl/hsot_cover_count.sv
hw/rtl/hash_slot_owner_table.sv
test/hash_slot_owner_table_test.sv
